/* design/phb_pkg.sv */
package phb_pkg;

    // table depth and field widths
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int BYTE_W            = 8;
    localparam int REQ_W             = 2;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_CLEAR  = 2'd3
    } phb_req_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_BUCKET
    } phb_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // write permutation entry
        logic clear;       // empty all buckets, drop key in progress
        logic char_start;  // latch character item, issue permutation read
        logic hash_step;   // take permutation data as new hash
        logic commit;      // finish key: bucket update and result load
    } phb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;        // latched character is the final one
        logic out_free;    // result register can take a new result
    } phb_status_t;

endpackage

/* design/phb_if.sv */
// request channel
interface phb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] key_char;
    logic       last_char;
    logic [7:0] key_id;
    logic [7:0] perm_index;
    logic [7:0] perm_value;

    modport source (
        output valid, req_type, key_char, last_char, key_id, perm_index, perm_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, key_char, last_char, key_id, perm_index, perm_value,
        output ready
    );
endinterface

// result channel
interface phb_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] hash_value;
    logic [7:0] bucket_id;
    logic       collision;

    modport source (
        output valid, hash_value, bucket_id, collision,
        input  ready
    );
    modport sink (
        input  valid, hash_value, bucket_id, collision,
        output ready
    );
endinterface

/* design/pearson_hash_bucket_table.sv */
// load and clear items complete in the idle state; a non-final character goes through a
// registered permutation read, then the hash update; a final character goes through the
// permutation read, a registered bucket read and the bucket update, with its result
// registered at that update, and waits before it while the result register is full
// reset clears the running hash, the bucket valid bits and the result valid at once;
// the permutation table holds no reset value and must be loaded before use
module pearson_hash_bucket_table #(
    parameter int TABLE_ENTRIES = phb_pkg::TABLE_ENTRIES_DEF
) (
    input logic      clk,
    input logic      rst_n,
    phb_req_if.sink  req,
    phb_res_if.source res
);
    import phb_pkg::*;

    phb_cmd_t    cmd;
    phb_status_t status;

    // controller
    phb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .in_type  (req.req_type),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    phb_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .req_type   (req.req_type),
        .key_char   (req.key_char),
        .last_char  (req.last_char),
        .key_id     (req.key_id),
        .perm_index (req.perm_index),
        .perm_value (req.perm_value),
        .res_valid  (res.valid),
        .res_ready  (res.ready),
        .hash_value (res.hash_value),
        .bucket_id  (res.bucket_id),
        .collision  (res.collision)
    );

endmodule

/* design/phb_ctrl.sv */
module phb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_type,
    input  phb_pkg::phb_status_t status,
    output phb_pkg::phb_cmd_t    cmd
);
    import phb_pkg::*;

    phb_state_t state_reg;
    phb_state_t state_next;
    phb_req_t   req_code;

    assign req_code = phb_req_t'(in_type);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (req_code) inside
                        REQ_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        REQ_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        REQ_INSERT, REQ_LOOKUP:
                        begin
                            cmd.char_start = 1'b1;
                            state_next     = ST_HASH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                state_next    = status.last ? ST_BUCKET : ST_IDLE;
            end
            ST_BUCKET:
            begin
                // hold until the result register frees up
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/phb_datapath.sv */
module phb_datapath #(
    parameter int TABLE_ENTRIES = phb_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  phb_pkg::phb_cmd_t    cmd,
    output phb_pkg::phb_status_t status,
    input  logic [1:0]          req_type,
    input  logic [7:0]          key_char,
    input  logic                last_char,
    input  logic [7:0]          key_id,
    input  logic [7:0]          perm_index,
    input  logic [7:0]          perm_value,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [7:0]          hash_value,
    output logic [7:0]          bucket_id,
    output logic                collision
);
    import phb_pkg::*;

    localparam int IdxW = $clog2(TABLE_ENTRIES);

    // memories
    logic [BYTE_W-1:0]        perm_mem [TABLE_ENTRIES];
    logic [BYTE_W-1:0]        bkt_mem  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] bkt_valid_reg;

    logic [BYTE_W-1:0] perm_rdata_reg;
    logic [BYTE_W-1:0] bkt_rdata_reg;
    logic [BYTE_W-1:0] hash_reg;
    logic [BYTE_W-1:0] key_hash_reg;
    logic [BYTE_W-1:0] id_reg;
    logic              last_reg;
    logic              insert_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_hash_reg;
    logic [BYTE_W-1:0] out_id_reg;
    logic              out_coll_reg;

    logic [IdxW-1:0]   perm_addr;
    logic [IdxW-1:0]   key_idx;
    logic [BYTE_W-1:0] held;
    logic              bkt_wr;
    logic              bkt_rd;

    assign perm_addr = IdxW'(hash_reg ^ key_char);
    assign key_idx   = IdxW'(key_hash_reg);
    assign bkt_rd    = cmd.hash_step && last_reg;

    // bucket content before this key, empty when never written since clear
    assign held   = bkt_valid_reg[key_idx] ? bkt_rdata_reg : '0;
    assign bkt_wr = cmd.commit && insert_reg && (held == '0);

    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || res_ready;

    // permutation memory: load write, registered read per character
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            perm_mem[IdxW'(perm_index)] <= perm_value;
        end
        if (cmd.char_start)
        begin
            perm_rdata_reg <= perm_mem[perm_addr];
        end
    end

    // bucket memory: registered read at final hash, write on empty insert
    always_ff @(posedge clk)
    begin
        if (bkt_rd)
        begin
            bkt_rdata_reg <= bkt_mem[IdxW'(perm_rdata_reg)];
        end
        if (bkt_wr)
        begin
            bkt_mem[key_idx] <= id_reg;
        end
    end

    // bucket valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bkt_valid_reg <= '0;
        end
        else if (cmd.clear)
        begin
            bkt_valid_reg <= '0;
        end
        else if (bkt_wr)
        begin
            bkt_valid_reg[key_idx] <= 1'b1;
        end
    end

    // running hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
        end
        else if (cmd.clear)
        begin
            hash_reg <= '0;
        end
        else if (cmd.hash_step)
        begin
            hash_reg <= last_reg ? '0 : perm_rdata_reg;
        end
    end

    // character item fields
    always_ff @(posedge clk)
    begin
        if (cmd.char_start)
        begin
            last_reg   <= last_char;
            insert_reg <= (phb_req_t'(req_type) == REQ_INSERT);
            id_reg     <= key_id;
        end
        if (bkt_rd)
        begin
            key_hash_reg <= perm_rdata_reg;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hash_reg <= key_hash_reg;
            out_id_reg   <= held;
            out_coll_reg <= insert_reg && (held != '0);
        end
    end

    assign res_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;
    assign bucket_id  = out_id_reg;
    assign collision  = out_coll_reg;

endmodule

/* tb/tb_pearson_hash_bucket_table.sv */
module tb_pearson_hash_bucket_table;
    timeunit 1ns;
    timeprecision 1ps;

    import phb_pkg::*;

    localparam int RANDOM_ITEMS   = 960;
    localparam int IDLE_PCT       = 11;
    localparam int QUIET_START    = 2000;
    localparam int QUIET_END      = 3500;
    localparam int HOLD_AFTER     = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_KEY_LEN    = 6;

    // one request transfer, plus a flag that holds it back until all results are in
    typedef struct {
        phb_req_t   kind;
        logic [7:0] ch;
        logic       last;
        logic [7:0] id;
        logic [7:0] idx;
        logic [7:0] val;
        bit         drain;
    } hash_req_t;

    typedef struct {
        logic [7:0] hash;
        logic [7:0] held;
        logic       coll;
    } bucket_result_t;

    typedef struct {
        logic [7:0] chars [MAX_KEY_LEN];
        int         len;
    } key_str_t;

    logic clk;
    logic rst_n;

    phb_req_if req_ch ();
    phb_res_if res_ch ();

    pearson_hash_bucket_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // shadow copy of the block state
    bit [7:0] perm_mem   [256];
    bit [7:0] bucket_mem [256];
    bit [7:0] partial_hash;

    hash_req_t      request_q [$];
    bucket_result_t bucket_results_q [$];
    key_str_t       key_pool [$];
    hash_req_t      cur_item;
    bit             drain_next;

    int errors;
    int cycle_count;
    int quiet_cycles;
    int result_count;
    int stall_left;
    bit hold_done;

    // applies one accepted request to the shadow state, queues the expected result
    function automatic void hash_and_bucket_update(hash_req_t r);
        logic [7:0]     h;
        bucket_result_t e;
        case (r.kind)
            REQ_LOAD: perm_mem[r.idx] = r.val;
            REQ_CLEAR:
            begin
                foreach (bucket_mem[i])
                    bucket_mem[i] = 8'd0;
                partial_hash = 8'd0;
            end
            default:
            begin
                h = perm_mem[partial_hash ^ r.ch];
                if (!r.last)
                    partial_hash = h;
                else
                begin
                    partial_hash = 8'd0;
                    e.hash = h;
                    e.held = bucket_mem[h];
                    e.coll = 1'b0;
                    if (r.kind == REQ_INSERT)
                    begin
                        if (bucket_mem[h] == 8'd0)
                            bucket_mem[h] = r.id;
                        else
                            e.coll = 1'b1;
                    end
                    bucket_results_q.push_back(e);
                end
            end
        endcase
    endfunction

    function automatic void push_req(phb_req_t kind, logic [7:0] ch, logic last,
                                     logic [7:0] id, logic [7:0] idx, logic [7:0] val);
        hash_req_t r;
        r.kind  = kind;
        r.ch    = ch;
        r.last  = last;
        r.id    = id;
        r.idx   = idx;
        r.val   = val;
        r.drain = drain_next;
        drain_next = 1'b0;
        request_q.push_back(r);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // character items of one key; mixed keys change mode before the last character
    function automatic void send_key(key_str_t k, phb_req_t mode, bit mixed, logic [7:0] id);
        phb_req_t kind;
        for (int i = 0; i < k.len; i++)
        begin
            kind = mode;
            if (mixed && i != k.len - 1)
                kind = ($urandom_range(1) != 0) ? REQ_INSERT : REQ_LOOKUP;
            push_req(kind, k.chars[i], i == k.len - 1, id, rand_byte(), rand_byte());
        end
    endfunction

    function automatic key_str_t random_key();
        key_str_t k;
        k.len = ($urandom_range(99) < 80) ? $urandom_range(1, 3)
                                          : $urandom_range(4, MAX_KEY_LEN);
        foreach (k.chars[i])
            k.chars[i] = rand_byte();
        return k;
    endfunction

    function automatic key_str_t fixed_key(int len, logic [7:0] c0, logic [7:0] c1,
                                           logic [7:0] c2);
        key_str_t k;
        k.len = len;
        foreach (k.chars[i])
            k.chars[i] = 8'd0;
        k.chars[0] = c0;
        k.chars[1] = c1;
        k.chars[2] = c2;
        return k;
    endfunction

    // clock and reset
    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        fork
            forever #5 clk = ~clk;
            begin
                repeat (6) @(posedge clk);
                rst_n <= 1'b1;
            end
        join_none
    end

    // request driver; the accepted item is applied to the shadow state first
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.req_type   <= REQ_LOAD;
            req_ch.key_char   <= 8'd0;
            req_ch.last_char  <= 1'b0;
            req_ch.key_id     <= 8'd0;
            req_ch.perm_index <= 8'd0;
            req_ch.perm_value <= 8'd0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                hash_and_bucket_update(cur_item);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (request_q.size() != 0
                    && !(request_q[0].drain && bucket_results_q.size() != 0)
                    && ((cycle_count >= QUIET_START && cycle_count < QUIET_END)
                        || $urandom_range(99) >= IDLE_PCT))
                begin
                    cur_item = request_q.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.req_type   <= cur_item.kind;
                    req_ch.key_char   <= cur_item.ch;
                    req_ch.last_char  <= cur_item.last;
                    req_ch.key_id     <= cur_item.id;
                    req_ch.perm_index <= cur_item.idx;
                    req_ch.perm_value <= cur_item.val;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver backpressure, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            result_count = 0;
            stall_left   = 0;
            hold_done    = 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                result_count++;
                if (bucket_results_q.size() == 0)
                begin
                    $error("unexpected result: hash_value %0h bucket_id %0h collision %0b",
                           res_ch.hash_value, res_ch.bucket_id, res_ch.collision);
                    errors++;
                end
                else
                begin
                    bucket_result_t e;
                    e = bucket_results_q.pop_front();
                    if (res_ch.hash_value !== e.hash)
                    begin
                        $error("hash_value mismatch: expected %0h, actual %0h",
                               e.hash, res_ch.hash_value);
                        errors++;
                    end
                    if (res_ch.bucket_id !== e.held)
                    begin
                        $error("bucket_id mismatch: expected %0h, actual %0h",
                               e.held, res_ch.bucket_id);
                        errors++;
                    end
                    if (res_ch.collision !== e.coll)
                    begin
                        $error("collision mismatch: expected %0b, actual %0b",
                               e.coll, res_ch.collision);
                        errors++;
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!hold_done && result_count >= HOLD_AFTER)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= (cycle_count >= QUIET_START && cycle_count < QUIET_END)
                                || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // cycle count and watchdog on cycles without any transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count  <= 0;
            quiet_cycles <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [7:0] perm [256];
        logic [7:0] tmp;
        int         j;
        int         base;
        int         pick;
        key_str_t   k;
        phb_req_t   mode;

        errors     = 0;
        drain_next = 1'b0;

        // full permutation load so that every table read hits a written entry
        foreach (perm[i])
            perm[i] = 8'(i);
        for (int i = 255; i > 0; i--)
        begin
            j       = $urandom_range(i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < 256; i++)
            push_req(REQ_LOAD, rand_byte(), 1'($urandom_range(1)), rand_byte(), 8'(i),
                     perm[i]);

        // directed: extremes, store and hit, collision, id zero, mixed modes
        send_key(fixed_key(1, 8'h00, 8'h00, 8'h00), REQ_INSERT, 1'b0, 8'hFF);
        send_key(fixed_key(1, 8'h00, 8'h00, 8'h00), REQ_LOOKUP, 1'b0, 8'h00);
        send_key(fixed_key(1, 8'h00, 8'h00, 8'h00), REQ_INSERT, 1'b0, 8'h01);
        send_key(fixed_key(1, 8'hFF, 8'h00, 8'h00), REQ_INSERT, 1'b0, 8'h00);
        send_key(fixed_key(1, 8'hFF, 8'h00, 8'h00), REQ_LOOKUP, 1'b0, 8'hFF);
        send_key(fixed_key(3, 8'h12, 8'h34, 8'h56), REQ_INSERT, 1'b0, 8'h80);
        send_key(fixed_key(3, 8'h12, 8'h34, 8'h56), REQ_LOOKUP, 1'b0, 8'h00);
        push_req(REQ_INSERT, 8'hA5, 1'b0, 8'h55, 8'h00, 8'h00);
        push_req(REQ_LOOKUP, 8'h5A, 1'b1, 8'hAA, 8'h00, 8'h00);
        push_req(REQ_LOOKUP, 8'h5A, 1'b0, 8'h00, 8'h00, 8'h00);
        push_req(REQ_INSERT, 8'hA5, 1'b1, 8'h7F, 8'h00, 8'h00);
        // clear drops a key in progress and empties the buckets
        push_req(REQ_INSERT, 8'h3C, 1'b0, 8'h10, 8'h00, 8'h00);
        push_req(REQ_CLEAR, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_key(fixed_key(1, 8'h00, 8'h00, 8'h00), REQ_LOOKUP, 1'b0, 8'h00);
        // permutation rewrite at both ends of the index range
        push_req(REQ_LOAD, 8'h00, 1'b0, 8'h00, 8'hFF, perm[0]);
        push_req(REQ_LOAD, 8'hFF, 1'b1, 8'hFF, 8'h00, perm[255]);
        send_key(fixed_key(2, 8'hFF, 8'h00, 8'h00), REQ_INSERT, 1'b0, 8'h2A);
        send_key(fixed_key(2, 8'hFF, 8'h00, 8'h00), REQ_LOOKUP, 1'b0, 8'h00);

        // random part: mostly whole keys, some reused, with loads, clears and noise
        drain_next = 1'b1;
        base = request_q.size();
        while (request_q.size() - base < RANDOM_ITEMS)
        begin
            if (request_q.size() - base >= RANDOM_ITEMS / 2
                && request_q.size() - base < RANDOM_ITEMS / 2 + 8)
                drain_next = 1'b1;
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                if (key_pool.size() != 0 && $urandom_range(99) < 40)
                    k = key_pool[$urandom_range(key_pool.size() - 1)];
                else
                begin
                    k = random_key();
                    key_pool.push_back(k);
                    if (key_pool.size() > 40)
                        void'(key_pool.pop_front());
                end
                mode = ($urandom_range(1) != 0) ? REQ_INSERT : REQ_LOOKUP;
                send_key(k, mode, $urandom_range(99) < 10,
                         ($urandom_range(99) < 5) ? 8'd0 : 8'($urandom_range(1, 255)));
            end
            else if (pick < 85)
                push_req(REQ_LOAD, rand_byte(), 1'($urandom_range(1)), rand_byte(),
                         rand_byte(), rand_byte());
            else if (pick < 87)
            begin
                // partial key cut off by a clear
                k = random_key();
                for (int i = 0; i < k.len; i++)
                    push_req(($urandom_range(1) != 0) ? REQ_INSERT : REQ_LOOKUP,
                             k.chars[i], 1'b0, rand_byte(), rand_byte(), rand_byte());
                push_req(REQ_CLEAR, rand_byte(), 1'($urandom_range(1)), rand_byte(),
                         rand_byte(), rand_byte());
            end
            else
                push_req(($urandom_range(1) != 0) ? REQ_INSERT : REQ_LOOKUP, rand_byte(),
                         1'($urandom_range(1)), rand_byte(), rand_byte(), rand_byte());
        end

        // wait for the stimulus to drain and every result to arrive
        @(posedge rst_n);
        @(negedge clk);
        while (request_q.size() != 0 || req_ch.valid || bucket_results_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && bucket_results_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
